FILE: src/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion failed: ante -> cons");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion failed: ante => cons");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: src/pli_pkg.sv
// Types and constants for the prefix-length integer decoder.
package pli_pkg;

	localparam logic [1:0] MODE_SIGNED   = 2'd0;
	localparam logic [1:0] MODE_UNSIGNED = 2'd1;
	localparam logic [1:0] MODE_FIXED    = 2'd2;
	localparam logic [1:0] MODE_SKIP     = 2'd3;

	localparam logic [1:0] PFX_FOUR = 2'b11;
	localparam logic [1:0] PFX_TWO  = 2'b10;

	localparam logic [31:0] EXT_FOUR = 32'hC000_0000;
	localparam logic [31:0] EXT_TWO  = 32'hFFFF_C000;
	localparam logic [31:0] EXT_ONE  = 32'hFFFF_FF80;

	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} pli_in_t;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  byte_count;
	} pli_out_t;

endpackage

FILE: src/prefix_length_integer_decoder.sv
// Prefix-length integer decoder: byte stream in, decoded 32-bit words out.
//
// Usage:
//   src channel (src_valid/src_ready/src_data) carries one stream byte per
//   transfer plus a mode, which is looked at only on the first byte of a datum.
//   dst channel (dst_valid/dst_ready/dst_data) carries one decoded word and
//   its byte count per completed datum; skip-mode data produce nothing.
//   Throughput is one byte per cycle. A byte is captured into an input
//   register, decoded by single-pass logic against the datum state, and a
//   completed word lands in the result register, which drives dst_valid
//   and dst_data once the last byte of a datum has left the input register.
//   When the receiver stalls, the result register holds its word and bytes
//   that do not complete a datum keep flowing; only a byte that completes
//   a datum waits in the input register, and src_ready drops once that
//   register is full and blocked.
//   Reset (arst_n low) clears the datum state, both valid flags, and drops
//   any partially received datum; the next byte is treated as a first byte.
`include "assert_macros.svh"

module prefix_length_integer_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_ready,
	input  pli_pkg::pli_in_t  src_data,
	output logic            dst_valid,
	input  logic            dst_ready,
	output pli_pkg::pli_out_t dst_data
);
	import pli_pkg::*;

	// input register
	logic        valid_s1;
	pli_in_t     item_s1;

	// datum state
	logic        busy_q;
	logic [1:0]  bytes_left_q;
	logic [1:0]  mode_q;
	logic [31:0] acc_q;
	logic        neg_q;
	logic [2:0]  total_q;

	// result register
	logic        out_valid_q;
	pli_out_t    out_q;

	logic        busy_n;
	logic [1:0]  bytes_left_n;
	logic [1:0]  mode_n;
	logic [31:0] acc_n;
	logic        neg_n;
	logic [2:0]  total_n;
	logic        emit;
	logic        advance;
	logic [31:0] ext_mask;
	logic [7:0]  b;
	logic        count_legal;

	assign b = item_s1.data_byte;

	always_comb begin
		mode_n  = mode_q;
		neg_n   = neg_q;
		total_n = total_q;
		acc_n   = {acc_q[23:0], b};
		bytes_left_n = bytes_left_q - 2'd1;
		if (!busy_q) begin
			mode_n = item_s1.mode;
			neg_n  = 1'b0;
			if (item_s1.mode == MODE_FIXED) begin
				total_n = LEN_FOUR;
				acc_n   = {24'd0, b};
			end else if (b[7:6] == PFX_FOUR) begin
				total_n = LEN_FOUR;
				acc_n   = {26'd0, b[5:0]};
				neg_n   = (item_s1.mode == MODE_SIGNED) && b[5];
			end else if (b[7:6] == PFX_TWO) begin
				total_n = LEN_TWO;
				acc_n   = {26'd0, b[5:0]};
				neg_n   = (item_s1.mode == MODE_SIGNED) && b[5];
			end else begin
				total_n = LEN_ONE;
				acc_n   = {25'd0, b[6:0]};
				neg_n   = (item_s1.mode == MODE_SIGNED) && b[6];
			end
			bytes_left_n = total_n[1:0] - 2'd1;
		end
		busy_n = (bytes_left_n != 2'd0);
		emit   = valid_s1 && !busy_n && (mode_n != MODE_SKIP);
	end

	always_comb begin
		case (total_n)
			LEN_FOUR: ext_mask = EXT_FOUR;
			LEN_TWO:  ext_mask = EXT_TWO;
			default:  ext_mask = EXT_ONE;
		endcase
		if (!(mode_n == MODE_SIGNED && neg_n))
			ext_mask = '0;
	end

	// a completing byte needs a free (or draining) result slot
	assign advance   = valid_s1 && (!emit || !out_valid_q || dst_ready);
	assign src_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready)
			item_s1 <= src_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			bytes_left_q <= 2'd0;
			mode_q       <= MODE_SIGNED;
			acc_q        <= '0;
			neg_q        <= 1'b0;
			total_q      <= 3'd0;
		end else if (advance) begin
			busy_q       <= busy_n;
			bytes_left_q <= bytes_left_n;
			mode_q       <= mode_n;
			acc_q        <= acc_n;
			neg_q        <= neg_n;
			total_q      <= total_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (dst_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q.value      <= acc_n | ext_mask;
			out_q.byte_count <= total_n;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

	assign count_legal = (dst_data.byte_count == LEN_ONE) || (dst_data.byte_count == LEN_TWO)
		|| (dst_data.byte_count == LEN_FOUR);

	`ASSERT_IMP(a_busy_has_left, clk, arst_n, busy_q, bytes_left_q != 2'd0)
	`ASSERT_IMP(a_fixed_len, clk, arst_n, busy_q && mode_q == MODE_FIXED, total_q == LEN_FOUR)
	`ASSERT_NXT(a_emit_lands, clk, arst_n, advance && emit, dst_valid)
	`ASSERT_IMP(a_count_legal, clk, arst_n, dst_valid, count_legal)

endmodule

FILE: sim/tb_prefix_length_integer_decoder.sv
// Self-checking testbench for the prefix-length integer decoder: directed table plus random bytes.
`timescale 1ns / 1ps

module tb_prefix_length_integer_decoder;

	import pli_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 338;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		pli_in_t  item;
		bit       typed;
		pli_out_t word;
	} dir_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_ready;
	pli_in_t  src_data = '0;
	logic     dst_valid;
	logic     dst_ready = 1'b0;
	pli_out_t dst_data;

	// predicted decoder state
	logic        busy_q;
	logic [1:0]  left_q;
	logic [1:0]  mode_q;
	logic [31:0] acc_q;
	logic        neg_q;
	logic [2:0]  len_q;

	pli_out_t expected_words[$];
	dir_row_t dir_rows[$];
	int       fail_count = 0;
	int       idle_cycles = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	prefix_length_integer_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	// Advance the predicted state by one stream byte; done marks a completed word.
	task automatic decode_byte(input pli_in_t item, output logic done, output pli_out_t word);
		logic [7:0] b;
		b = item.data_byte;
		done = 1'b0;
		word = '0;
		if (!busy_q) begin
			mode_q = item.mode;
			neg_q = 1'b0;
			if (mode_q == MODE_FIXED) begin
				len_q = LEN_FOUR;
				acc_q = {24'd0, b};
			end else if (b[7:6] == PFX_FOUR) begin
				len_q = LEN_FOUR;
				acc_q = {26'd0, b[5:0]};
				neg_q = (mode_q == MODE_SIGNED) && b[5];
			end else if (b[7:6] == PFX_TWO) begin
				len_q = LEN_TWO;
				acc_q = {26'd0, b[5:0]};
				neg_q = (mode_q == MODE_SIGNED) && b[5];
			end else begin
				len_q = LEN_ONE;
				acc_q = {25'd0, b[6:0]};
				neg_q = (mode_q == MODE_SIGNED) && b[6];
			end
			left_q = len_q[1:0] - 2'd1;
			busy_q = 1'b1;
		end else begin
			acc_q = {acc_q[23:0], b};
			left_q = left_q - 2'd1;
		end
		if (left_q == 2'd0) begin
			busy_q = 1'b0;
			if (mode_q != MODE_SKIP) begin
				word.value = acc_q;
				if (mode_q == MODE_SIGNED && neg_q) begin
					case (len_q)
						LEN_FOUR: word.value = acc_q | EXT_FOUR;
						LEN_TWO:  word.value = acc_q | EXT_TWO;
						default:  word.value = acc_q | EXT_ONE;
					endcase
				end
				word.byte_count = len_q;
				done = 1'b1;
			end
		end
	endtask

	// One source transfer; typed rows supply their own expected word.
	task automatic push_byte(input pli_in_t item, input bit typed, input pli_out_t typed_word);
		logic     done;
		pli_out_t word;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			src_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		src_valid <= 1'b1;
		src_data <= item;
		do @(posedge clk); while (!src_ready);
		decode_byte(item, done, word);
		if (done) begin
			expected_words.push_back(typed ? typed_word : word);
		end
	endtask

	task automatic add_row(input logic [1:0] m, input logic [7:0] b, input bit typed,
			input logic [31:0] v, input logic [2:0] n);
		dir_row_t r;
		r.item.mode = m;
		r.item.data_byte = b;
		r.typed = typed;
		r.word.value = v;
		r.word.byte_count = n;
		dir_rows.push_back(r);
	endtask

	task automatic wait_for_drain();
		src_valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		pli_out_t exp_word;
		if (arst_n && dst_valid && dst_ready) begin
			if (expected_words.size() == 0) begin
				note_failure($sformatf("unexpected word value=%h count=%0d",
					dst_data.value, dst_data.byte_count));
			end else begin
				exp_word = expected_words.pop_front();
				if (dst_data.value !== exp_word.value) begin
					note_failure($sformatf("value expected %h actual %h",
						exp_word.value, dst_data.value));
				end
				if (dst_data.byte_count !== exp_word.byte_count) begin
					note_failure($sformatf("byte_count expected %0d actual %0d",
						exp_word.byte_count, dst_data.byte_count));
				end
			end
		end
		dst_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && src_ready) || (dst_valid && dst_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("prefix_length_integer_decoder test failed");
				$finish;
			end
		end
	end

	initial begin
		pli_in_t  item;
		pli_out_t none;
		int       r;
		none = '0;
		busy_q = 1'b0;
		left_q = '0;
		mode_q = '0;
		acc_q = '0;
		neg_q = 1'b0;
		len_q = '0;

		// one-byte extremes
		add_row(MODE_SIGNED,   8'h00, 1'b1, 32'h0000_0000, LEN_ONE);
		add_row(MODE_SIGNED,   8'h40, 1'b1, 32'hFFFF_FFC0, LEN_ONE);
		add_row(MODE_SIGNED,   8'h7F, 1'b1, 32'hFFFF_FFFF, LEN_ONE);
		add_row(MODE_UNSIGNED, 8'h7F, 1'b1, 32'h0000_007F, LEN_ONE);
		// two-byte negative
		add_row(MODE_SIGNED,   8'hBF, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'hFF, 1'b1, 32'hFFFF_FFFF, LEN_TWO);
		// four-byte negative, mode changes mid-datum are ignored
		add_row(MODE_SIGNED,   8'hE0, 1'b0, 32'h0, 3'd0);
		add_row(MODE_UNSIGNED, 8'h00, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SKIP,     8'h00, 1'b0, 32'h0, 3'd0);
		add_row(MODE_FIXED,    8'h00, 1'b1, 32'hE000_0000, LEN_FOUR);
		// four-byte unsigned maximum
		add_row(MODE_UNSIGNED, 8'hFF, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'hFF, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'hFF, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'hFF, 1'b1, 32'h3FFF_FFFF, LEN_FOUR);
		// fixed big-endian
		add_row(MODE_FIXED,    8'h80, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'h01, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SKIP,     8'h02, 1'b0, 32'h0, 3'd0);
		add_row(MODE_UNSIGNED, 8'h03, 1'b1, 32'h8001_0203, LEN_FOUR);
		// skip of each length, no words
		add_row(MODE_SKIP,     8'hC1, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'hAA, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'hBB, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'hCC, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SKIP,     8'h85, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SIGNED,   8'h7F, 1'b0, 32'h0, 3'd0);
		add_row(MODE_SKIP,     8'h12, 1'b0, 32'h0, 3'd0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			push_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].word);
		end
		wait_for_drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int k = 0; k < PHASE_BYTES; k++) begin
				r = $urandom_range(7);
				item.mode = 2'($urandom_range(3));
				item.data_byte = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
				push_byte(item, 1'b0, none);
				if (phase == 2 && k == PHASE_BYTES / 2) begin
					wait_for_drain();
				end
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		src_valid <= 1'b0;

		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_words.size() != 0) begin
			note_failure($sformatf("%0d expected words never arrived", expected_words.size()));
		end
		if (fail_count == 0) begin
			$display("prefix_length_integer_decoder test passed");
		end else begin
			$display("prefix_length_integer_decoder test failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/pli_pkg.sv
src/prefix_length_integer_decoder.sv
sim/tb_prefix_length_integer_decoder.sv
